// ===== rtl/pevq_pkg.sv =====
// shared types and codes of the priority event queue
package pevq_pkg;

  // opcode of an input beat
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  // status of a result beat
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = 1'd1;

  // reset capacity before clamping to the built depth
  localparam int CAPACITY_RESET = 16;

  // broadcast control from the queue controller to every cell
  typedef struct packed {
    logic ins_en;     // insert the pushed entry, cells behind it move back
    logic shl_en;     // every cell takes its back neighbor (front entry leaves)
    logic ovw_en;     // with shl_en: the last held cell loads the pushed entry
    logic zero_push;  // pushed priority is zero: append behind held entries
  } cell_ctl_t;

endpackage

// ===== rtl/pevq_if.sv =====
// input and result channel interfaces of the priority event queue
interface pevq_in_if #(
  parameter int EVENT_BITS    = 16,
  parameter int PRIORITY_BITS = 8
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic [EVENT_BITS-1:0]    event_code;
  logic [PRIORITY_BITS-1:0] event_priority;

  modport source (output valid, output opcode, output event_code,
                  output event_priority, input ready);
  modport sink   (input valid, input opcode, input event_code,
                  input event_priority, output ready);
endinterface

interface pevq_out_if #(
  parameter int EVENT_BITS    = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int CNT_W         = 5
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [EVENT_BITS-1:0]    popped_event;
  logic [PRIORITY_BITS-1:0] popped_priority;
  logic [CNT_W-1:0]         count_after;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output status, output popped_event,
                  output popped_priority, output count_after, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input status, input popped_event,
                  input popped_priority, input count_after, input is_empty,
                  input is_full, output ready);
endinterface

// ===== rtl/priority_event_queue.sv =====
// top level of the priority event queue: cell row, fill count and result register
//
// Bounded queue of events kept in priority order, equal priorities in arrival
// order. Each input beat on in_ch carries an opcode (push, pop, clear or no-op),
// an event code and a priority; each accepted beat gives exactly one result beat
// on out_ch with a status, the popped entry (zero unless a pop succeeded), the
// fill count after the operation and empty/full flags.
// The entries sit in a row of cells, front entry in cell 0. On a push every cell
// compares its priority with the pushed one against its front neighbor's verdict,
// so the new entry lands and the entries behind it move back one cell in the
// same cycle; a pop moves every cell forward by one.
// The result is registered and appears in the cycle after the input beat is accepted.
// Throughput: one beat per cycle while results drain; the whole cell row updates together.
// in_ch.ready stays high while the result register is empty or being drained,
// so a stalled receiver holds back at most one result and then the input.
// Reset (rst_n low at a clock edge) empties the queue, sets the capacity to
// the built depth capped at 16 and disables overwrite. Configuration writes must go in
// only while the block is idle, unchecked by the block; capacity writes empty the queue.
module priority_event_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int EVENT_BITS    = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pevq_in_if.sink                           in_ch,
  pevq_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [pevq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pevq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CAP_RST = (QUEUE_DEPTH < pevq_pkg::CAPACITY_RESET) ?
                           QUEUE_DEPTH : pevq_pkg::CAPACITY_RESET;

  // cell row wiring
  logic [EVENT_BITS-1:0]    cell_ev [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_pr [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_after;
  logic [QUEUE_DEPTH-1:0]   below_vec;
  logic [QUEUE_DEPTH-1:0]   last_vec;
  pevq_pkg::cell_ctl_t      ctl;

  // queue control state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic             ovw_r, ovw_nxt;

  // result register
  logic                     out_valid_r;
  pevq_pkg::status_t        status_r, status_nxt;
  logic [EVENT_BITS-1:0]    pop_ev_r, pop_ev_nxt;
  logic [PRIORITY_BITS-1:0] pop_pr_r, pop_pr_nxt;
  logic [CNT_W-1:0]         cnt_out_r;
  logic                     empty_r, full_r;

  logic              accept;
  logic              full;
  logic              last_after;
  pevq_pkg::opcode_t op;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op          = pevq_pkg::opcode_t'(in_ch.opcode);
  assign full        = count_r >= cap_r;
  // every held entry outranks the push: it would land behind the last one
  assign last_after  = |(last_vec & cell_after);

  // row of cells, front entry in cell 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     prev_after;
    logic [EVENT_BITS-1:0]    prev_ev, next_ev;
    logic [PRIORITY_BITS-1:0] prev_pr, next_pr;

    assign below_vec[i] = CNT_W'(i) < count_r;
    assign last_vec[i]  = CNT_W'(i + 1) == count_r;

    if (i == 0) begin : g_front
      assign prev_after = 1'b1;
      assign prev_ev    = cell_ev[i];
      assign prev_pr    = cell_pr[i];
    end else begin : g_mid
      assign prev_after = cell_after[i-1];
      assign prev_ev    = cell_ev[i-1];
      assign prev_pr    = cell_pr[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_back
      assign next_ev = cell_ev[i];
      assign next_pr = cell_pr[i];
    end else begin : g_inner
      assign next_ev = cell_ev[i+1];
      assign next_pr = cell_pr[i+1];
    end

    pevq_cell #(
      .EVENT_BITS    (EVENT_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .push_ev     (in_ch.event_code),
      .push_pr     (in_ch.event_priority),
      .below_count (below_vec[i]),
      .at_last     (last_vec[i]),
      .prev_after  (prev_after),
      .prev_ev     (prev_ev),
      .prev_pr     (prev_pr),
      .next_ev     (next_ev),
      .next_pr     (next_pr),
      .ev          (cell_ev[i]),
      .pr          (cell_pr[i]),
      .after       (cell_after[i])
    );
  end

  // operation decode, fill count and result
  always_comb begin
    ctl           = '0;
    ctl.zero_push = in_ch.event_priority == '0;
    count_nxt     = count_r;
    status_nxt    = pevq_pkg::ST_DONE;
    pop_ev_nxt    = '0;
    pop_pr_nxt    = '0;
    if (accept) begin
      unique case (op)
        pevq_pkg::OP_PUSH: begin
          if (!full) begin
            ctl.ins_en = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
          end else if (ctl.zero_push) begin
            if (ovw_r) begin
              ctl.shl_en = 1'b1;
              ctl.ovw_en = 1'b1;
            end else begin
              status_nxt = pevq_pkg::ST_FULL;
            end
          end else if (last_after) begin
            status_nxt = pevq_pkg::ST_FULL;
          end else begin
            ctl.ins_en = 1'b1;
          end
        end
        pevq_pkg::OP_POP: begin
          if (count_r == '0) begin
            status_nxt = pevq_pkg::ST_EMPTY;
          end else begin
            ctl.shl_en = 1'b1;
            count_nxt  = count_r - CNT_W'(1);
            pop_ev_nxt = cell_ev[0];
            pop_pr_nxt = cell_pr[0];
          end
        end
        pevq_pkg::OP_CLEAR: begin
          count_nxt = '0;
        end
        pevq_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
    if (cfg_we && (cfg_index == pevq_pkg::REG_CAPACITY)) begin
      count_nxt = '0;
    end
  end

  // configuration writes, capacity clamped to 1..QUEUE_DEPTH
  always_comb begin
    cap_nxt = cap_r;
    ovw_nxt = ovw_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pevq_pkg::REG_CAPACITY: begin
          if (32'(cfg_data) > QUEUE_DEPTH) begin
            cap_nxt = CNT_W'(QUEUE_DEPTH);
          end else if (cfg_data == '0) begin
            cap_nxt = CNT_W'(1);
          end else begin
            cap_nxt = CNT_W'(cfg_data);
          end
        end
        pevq_pkg::REG_OVERWRITE: begin
          ovw_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CNT_W'(CAP_RST);
      ovw_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      ovw_r   <= ovw_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      pop_ev_r  <= pop_ev_nxt;
      pop_pr_r  <= pop_pr_nxt;
      cnt_out_r <= count_nxt;
      empty_r   <= count_nxt == '0;
      full_r    <= count_nxt == cap_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.popped_event    = pop_ev_r;
  assign out_ch.popped_priority = pop_pr_r;
  assign out_ch.count_after     = cnt_out_r;
  assign out_ch.is_empty        = empty_r;
  assign out_ch.is_full         = full_r;

endmodule

// ===== rtl/pevq_cell.sv =====
// one slot of the sorted queue: holds an entry and trades it with its neighbors
module pevq_cell #(
  parameter int EVENT_BITS    = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                     clk,
  input  pevq_pkg::cell_ctl_t      ctl,
  input  logic [EVENT_BITS-1:0]    push_ev,
  input  logic [PRIORITY_BITS-1:0] push_pr,
  input  logic                     below_count,  // this slot holds an entry
  input  logic                     at_last,      // this slot holds the last entry
  input  logic                     prev_after,   // new entry goes behind the front neighbor
  input  logic [EVENT_BITS-1:0]    prev_ev,
  input  logic [PRIORITY_BITS-1:0] prev_pr,
  input  logic [EVENT_BITS-1:0]    next_ev,
  input  logic [PRIORITY_BITS-1:0] next_pr,
  output logic [EVENT_BITS-1:0]    ev,
  output logic [PRIORITY_BITS-1:0] pr,
  output logic                     after         // new entry goes behind this slot
);

  logic [EVENT_BITS-1:0]    ev_r, ev_nxt;
  logic [PRIORITY_BITS-1:0] pr_r, pr_nxt;
  logic                     load_here;
  logic                     from_prev;

  // held entry stays ahead of the pushed one when it is at least as urgent or the push has priority zero
  assign after     = ctl.zero_push ? below_count : (below_count && (pr_r >= push_pr));
  assign load_here = !after && prev_after;
  assign from_prev = !prev_after;

  // next slot contents
  always_comb begin
    ev_nxt = ev_r;
    pr_nxt = pr_r;
    if (ctl.shl_en) begin
      if (ctl.ovw_en && at_last) begin
        ev_nxt = push_ev;
        pr_nxt = push_pr;
      end else begin
        ev_nxt = next_ev;
        pr_nxt = next_pr;
      end
    end else if (ctl.ins_en) begin
      if (load_here) begin
        ev_nxt = push_ev;
        pr_nxt = push_pr;
      end else if (from_prev) begin
        ev_nxt = prev_ev;
        pr_nxt = prev_pr;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
    pr_r <= pr_nxt;
  end

  assign ev = ev_r;
  assign pr = pr_r;

endmodule
